### hw/rtl/sha512_sha384_hash_engine_top_defines.svh
// Assertion macros for the hash engine checker
`ifndef SHA512_SHA384_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA512_SHA384_HASH_ENGINE_TOP_DEFINES_SVH

// antecedent implies consequent on the next edge
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent on the same edge
`define SHA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sha_pkg.sv
// ============================================================================
// sha_pkg
// Types, constants and functions shared by the hash engine modules.
// ============================================================================
package sha_pkg;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last_word;
    } sha_in_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic        digest_last;
    } sha_out_t;

    // datapath operation codes
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_LOADIV  = 3'd1;
    localparam logic [2:0] OP_PUT     = 3'd2;
    localparam logic [2:0] OP_START   = 3'd3;
    localparam logic [2:0] OP_ROUND   = 3'd4;
    localparam logic [2:0] OP_FOLD    = 3'd5;
    localparam logic [2:0] OP_SHIFTCV = 3'd6;

    // word source codes for OP_PUT
    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_PAD  = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LEN  = 2'd3;

    localparam int ROUNDS = 80;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] src;
        logic       mode;
    } sha_cmd_t;

    typedef struct packed {
        logic [4:0] word_index;
        logic       round_last;
    } sha_stat_t;

    function automatic logic [63:0] iv_word(input logic mode, input logic [2:0] i);
        logic [63:0] r;
        begin
            r = 64'd0;
            if (!mode) begin
                case (i)
                    3'd0: r = 64'h6a09e667f3bcc908;
                    3'd1: r = 64'hbb67ae8584caa73b;
                    3'd2: r = 64'h3c6ef372fe94f82b;
                    3'd3: r = 64'ha54ff53a5f1d36f1;
                    3'd4: r = 64'h510e527fade682d1;
                    3'd5: r = 64'h9b05688c2b3e6c1f;
                    3'd6: r = 64'h1f83d9abfb41bd6b;
                    3'd7: r = 64'h5be0cd19137e2179;
                    default: r = 64'd0;
                endcase
            end else begin
                case (i)
                    3'd0: r = 64'hcbbb9d5dc1059ed8;
                    3'd1: r = 64'h629a292a367cd507;
                    3'd2: r = 64'h9159015a3070dd17;
                    3'd3: r = 64'h152fecd8f70e5939;
                    3'd4: r = 64'h67332667ffc00b31;
                    3'd5: r = 64'h8eb44a8768581511;
                    3'd6: r = 64'hdb0c2e0d64f98fa7;
                    3'd7: r = 64'h47b5481dbefa4fa4;
                    default: r = 64'd0;
                endcase
            end
            return r;
        end
    endfunction

    function automatic logic [63:0] kround(input logic [6:0] i);
        logic [63:0] k [0:79];
        begin
            k = '{
                64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
                64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
                64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
                64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
                64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
                64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
                64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
                64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
                64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
                64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
                64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
                64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
                64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
                64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
                64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
                64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
                64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
                64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
                64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
                64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
                64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
                64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
                64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
                64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
                64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
                64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
                64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
            if (i < 7'd80) begin
                return k[i];
            end
            return 64'd0;
        end
    endfunction

endpackage

### hw/rtl/sha_datapath.sv
// ============================================================================
// sha_datapath
// Block buffer, message schedule, working variables, chain value and length.
// ============================================================================
module sha_datapath
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha_cmd_t    cmd,
    input  sha_in_t     word,
    output sha_stat_t   stat,
    output logic [63:0] cv_head
);

    logic [63:0] block_reg [0:15];
    logic [63:0] sched_reg [0:15];
    logic [63:0] var_reg   [0:7];
    logic [63:0] cv_reg    [0:7];
    logic [4:0]  widx_reg;
    logic [63:0] bytes_reg;
    logic [6:0]  round_reg;
    logic [63:0] pad_word;
    logic [3:0]  n;
    logic [63:0] put_word;
    logic [63:0] w_new;
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] e;
    logic [63:0] a;
    logic [63:0] mask;

    always_comb
    begin
        n = (word.byte_count > 4'd8) ? 4'd8 : word.byte_count;
        mask = (n == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {n, 3'b000});
        pad_word = (word.data_word & mask) | (64'h8000000000000000 >> {n, 3'b000});
        case (cmd.src)
            SRC_DATA: put_word = (word.last_word && n != 4'd8) ? pad_word : word.data_word;
            SRC_PAD:  put_word = 64'h8000000000000000;
            SRC_ZERO: put_word = 64'd0;
            SRC_LEN:  put_word = {bytes_reg[60:0], 3'b000};
            default:  put_word = 64'd0;
        endcase
    end

    always_comb
    begin
        s0 = {sched_reg[1][0], sched_reg[1][63:1]} ^ {sched_reg[1][7:0], sched_reg[1][63:8]}
           ^ (sched_reg[1] >> 7);
        s1 = {sched_reg[14][18:0], sched_reg[14][63:19]}
           ^ {sched_reg[14][60:0], sched_reg[14][63:61]} ^ (sched_reg[14] >> 6);
        w_new = (round_reg < 7'd16) ? sched_reg[0] : sched_reg[0] + s0 + s1 + sched_reg[9];
        e = var_reg[4];
        a = var_reg[0];
        t1 = var_reg[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
           + ((e & var_reg[5]) ^ (~e & var_reg[6])) + kround(round_reg) + w_new;
        t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
           + ((a & var_reg[1]) ^ (a & var_reg[2]) ^ (var_reg[1] & var_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            widx_reg  <= 5'd0;
            bytes_reg <= 64'd0;
            round_reg <= 7'd0;
            for (int i = 0; i < 8; i++) begin
                cv_reg[i] <= iv_word(1'b0, 3'(i));
            end
        end else begin
            case (cmd.op)
                OP_LOADIV:
                begin
                    widx_reg  <= 5'd0;
                    bytes_reg <= 64'd0;
                    for (int i = 0; i < 8; i++) begin
                        cv_reg[i] <= iv_word(cmd.mode, 3'(i));
                    end
                end
                OP_PUT:
                begin
                    block_reg[widx_reg[3:0]] <= put_word;
                    widx_reg <= widx_reg + 5'd1;
                    if (cmd.src == SRC_DATA) begin
                        if (word.last_word) begin
                            bytes_reg <= bytes_reg + 64'(n);
                        end else begin
                            bytes_reg <= bytes_reg + 64'd8;
                        end
                    end
                end
                OP_START:
                begin
                    widx_reg  <= 5'd0;
                    round_reg <= 7'd0;
                    for (int i = 0; i < 16; i++) begin
                        sched_reg[i] <= block_reg[i];
                    end
                    for (int i = 0; i < 8; i++) begin
                        var_reg[i] <= cv_reg[i];
                    end
                end
                OP_ROUND:
                begin
                    round_reg <= round_reg + 7'd1;
                    for (int i = 0; i < 15; i++) begin
                        sched_reg[i] <= sched_reg[i + 1];
                    end
                    sched_reg[15] <= w_new;
                    var_reg[7] <= var_reg[6];
                    var_reg[6] <= var_reg[5];
                    var_reg[5] <= var_reg[4];
                    var_reg[4] <= var_reg[3] + t1;
                    var_reg[3] <= var_reg[2];
                    var_reg[2] <= var_reg[1];
                    var_reg[1] <= var_reg[0];
                    var_reg[0] <= t1 + t2;
                end
                OP_FOLD:
                begin
                    for (int i = 0; i < 8; i++) begin
                        cv_reg[i] <= cv_reg[i] + var_reg[i];
                    end
                end
                OP_SHIFTCV:
                begin
                    for (int i = 0; i < 7; i++) begin
                        cv_reg[i] <= cv_reg[i + 1];
                    end
                    cv_reg[7] <= cv_reg[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.word_index = widx_reg;
    assign stat.round_last = (round_reg == 7'(ROUNDS - 1));
    assign cv_head         = cv_reg[0];

endmodule

### hw/rtl/sha_ctrl.sv
// ============================================================================
// sha_ctrl
// Sequencer for word intake, padding, compression and digest output.
// ============================================================================
module sha_ctrl
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sha_in_t   in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      out_last,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data,
    input  sha_stat_t stat,
    output sha_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_IV    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       mode_reg;
    logic       final_reg;
    logic       final_next;
    logic       full_reg;
    logic       full_next;
    logic [2:0] ocnt_reg;
    logic [2:0] ocnt_next;
    logic       len_done_reg;
    logic       len_done_next;
    logic       nopad_reg;
    logic       nopad_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= 1'b0;
            final_reg    <= 1'b0;
            full_reg     <= 1'b0;
            ocnt_reg     <= 3'd0;
            len_done_reg <= 1'b0;
            nopad_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            final_reg    <= final_next;
            full_reg     <= full_next;
            ocnt_reg     <= ocnt_next;
            len_done_reg <= len_done_next;
            nopad_reg    <= nopad_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign out_valid = (state_reg == ST_OUT);
    assign out_last  = (ocnt_reg == (mode_reg ? 3'd5 : 3'd7));

    always_comb
    begin
        state_next    = state_reg;
        final_next    = final_reg;
        full_next     = full_reg;
        ocnt_next     = ocnt_reg;
        len_done_next = len_done_reg;
        nopad_next    = nopad_reg;
        cmd.op        = OP_NONE;
        cmd.src       = SRC_DATA;
        cmd.mode      = mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid) begin
                    cmd.op   = OP_LOADIV;
                    cmd.mode = cfg_data;
                end else if (in_valid) begin
                    cmd.op  = OP_PUT;
                    cmd.src = SRC_DATA;
                    if (in_word.last_word) begin
                        final_next    = 1'b1;
                        len_done_next = 1'b0;
                        nopad_next    = (in_word.byte_count < 4'd8);
                        state_next    = (stat.word_index == 5'd15) ? ST_ROUND : ST_PAD;
                        full_next     = (stat.word_index == 5'd14)
                                        && (in_word.byte_count < 4'd8);
                    end else begin
                        final_next = 1'b0;
                        if (stat.word_index == 5'd15) begin
                            state_next = ST_ROUND;
                        end
                    end
                    if (stat.word_index == 5'd15) begin
                        cmd.op = OP_PUT;
                    end
                end
            end
            ST_PAD:
            begin
                if (nopad_reg) begin
                    state_next = ST_FILL;
                end else begin
                    cmd.op     = OP_PUT;
                    cmd.src    = SRC_PAD;
                    nopad_next = 1'b1;
                    full_next  = (stat.word_index == 5'd14);
                    state_next = (stat.word_index == 5'd15) ? ST_ROUND : ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.op  = OP_PUT;
                cmd.src = SRC_ZERO;
                if (stat.word_index == 5'd15) begin
                    state_next = ST_ROUND;
                    if (full_reg) begin
                        full_next = 1'b0;
                    end else begin
                        cmd.src       = SRC_LEN;
                        len_done_next = 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                if (stat.word_index == 5'd16) begin
                    cmd.op = OP_START;
                end else begin
                    cmd.op = OP_ROUND;
                    if (stat.round_last) begin
                        state_next = ST_FOLD;
                    end
                end
            end
            ST_FOLD:
            begin
                cmd.op = OP_FOLD;
                if (!final_reg) begin
                    state_next = ST_IDLE;
                end else if (!nopad_reg) begin
                    state_next = ST_PAD;
                end else if (!len_done_reg) begin
                    state_next = ST_FILL;
                end else begin
                    ocnt_next  = 3'd0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready) begin
                    cmd.op    = OP_SHIFTCV;
                    ocnt_next = ocnt_reg + 3'd1;
                    if (out_last) begin
                        state_next = ST_IV;
                    end
                end
            end
            ST_IV:
            begin
                cmd.op     = OP_LOADIV;
                final_next = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/sha512_sha384_hash_engine_top.sv
// ============================================================================
// sha512_sha384_hash_engine_top
// SHA-512 / SHA-384 engine: word intake, padding, 80-round compression.
// ============================================================================
//  channel  | signals                         | payload
//  in       | in_valid / in_ready             | sha_in_t in_data
//  out      | out_valid / out_ready           | sha_out_t out_data
//  cfg      | cfg_valid / cfg_ready           | cfg_data (mode_select)
//
//  One word per cycle into the block buffer while idle and no cfg is pending;
//  every 16th word starts one compression (load, 80 rounds, fold) on the
//  single round unit. A last word adds padding and up to two compressions.
//  Reset loads the SHA-512 initial values; out stalls hold the digest word.
module sha512_sha384_hash_engine_top
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sha_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output sha_out_t out_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    sha_cmd_t    cmd;
    sha_stat_t   stat;
    logic [63:0] cv_head;
    logic        out_last;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_last  (out_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd)
    );

    sha_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .word    (in_data),
        .stat    (stat),
        .cv_head (cv_head)
    );

    assign out_data.digest_word = cv_head;
    assign out_data.digest_last = out_last;

endmodule

### hw/rtl/sha_checker.sv
// ============================================================================
// sha_checker
// Port-level checks for the hash engine, bound to the top level.
// ============================================================================
`include "sha512_sha384_hash_engine_top_defines.svh"

module sha_checker
    import sha_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input sha_out_t out_data,
    input logic     cfg_valid,
    input logic     cfg_ready
);

    `SHA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "digest word dropped while stalled")
    `SHA_ASSERT_SAME(a_no_in_during_out, clk, rst_n, out_valid, !in_ready, "input taken while digest pending")
    `SHA_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && out_ready && out_data.digest_last, !out_valid, "digest continues past last word")
    `SHA_ASSERT_SAME(a_cfg_idle, clk, rst_n, cfg_ready, !out_valid, "config open during output")

endmodule

bind sha512_sha384_hash_engine_top sha_checker u_sha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
